// File: rtl/core/voice_channel_allocator_core_assert.svh
// ----------------------------------------------------------------------------
// voice_channel_allocator_core_assert.svh
// Assertion macros used by the allocator checker. A user of a macro must
// have clk and arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef VOICE_CHANNEL_ALLOCATOR_CORE_ASSERT_SVH
`define VOICE_CHANNEL_ALLOCATOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define VCA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define VCA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/vca_pkg.sv
// ----------------------------------------------------------------------------
// vca_pkg
// Constants, codes and controller/datapath interface types of the voice
// channel allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package vca_pkg;

	localparam int NUM_CHANNELS = 6;
	localparam int COUNT_BITS   = 32;
	localparam int CH_BITS      = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int SEQ_W        = 32;
	localparam int NOTE_W       = 7;
	localparam int TIME_W       = 64;
	localparam int CHAN_W       = 3;

	typedef enum logic [1:0] {
		ACT_ON  = 2'd0,
		ACT_OFF = 2'd1,
		ACT_REL = 2'd2
	} action_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic               load;
		logic               scan;
		logic               apply;
		logic               rel_emit;
		logic               rel_empty;
		logic [CH_BITS-1:0] idx;
	} vca_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic [1:0] action;
		logic       any_held;
		logic       idx_held;
		logic       last_held;
		logic       out_free;
	} vca_stat_t;

	function automatic logic [SEQ_W-1:0] to_seq(input logic [COUNT_BITS-1:0] v);
		logic [63:0] w;
		begin
			w = 64'(v);
			return w[SEQ_W-1:0];
		end
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/vca_ctrl.sv
// ----------------------------------------------------------------------------
// vca_ctrl
// Sequencer of the allocator: takes an event, walks the channels one per cycle
// (release beats wait out a stall) and sends apply/release to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module vca_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire vca_pkg::vca_stat_t  stat,
	output vca_pkg::vca_cmd_t        cmd
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_APPLY = 4'b0100,
		ST_REL   = 4'b1000
	} state_t;

	state_t                      state_q, state_d;
	logic [vca_pkg::CH_BITS-1:0] idx_q, idx_d;
	logic                        idx_end;

	assign in_stall = (state_q != ST_IDLE);
	assign idx_end  = (idx_q == vca_pkg::CH_BITS'(vca_pkg::NUM_CHANNELS - 1));

	always_comb begin
		state_d       = state_q;
		idx_d         = idx_q;
		cmd           = '0;
		cmd.idx       = idx_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					idx_d    = '0;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				// release all goes straight to its own walk
				if (vca_pkg::action_t'(stat.action) == vca_pkg::ACT_REL) begin
					state_d = ST_REL;
				end else begin
					cmd.scan = 1'b1;
					if (idx_end) begin
						state_d = ST_APPLY;
					end else begin
						idx_d = idx_q + 1'b1;
					end
				end
			end
			ST_APPLY: begin
				if (stat.out_free) begin
					cmd.apply = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			ST_REL: begin
				if (!stat.any_held) begin
					if (stat.out_free) begin
						cmd.rel_empty = 1'b1;
						state_d       = ST_IDLE;
					end
				end else if (stat.idx_held) begin
					if (stat.out_free) begin
						cmd.rel_emit = 1'b1;
						if (stat.last_held) begin
							state_d = ST_IDLE;
						end else begin
							idx_d = idx_q + 1'b1;
						end
					end
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/vca_dp.sv
// ----------------------------------------------------------------------------
// vca_dp
// Datapath of the allocator: channel and voice records, the scan result
// registers, the event decision and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module vca_dp (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic [1:0]                   action,
	input  wire logic [vca_pkg::NOTE_W-1:0]   note,
	input  wire logic                         allow_steal,
	input  wire logic [vca_pkg::TIME_W-1:0]   sample_time,
	input  wire vca_pkg::vca_cmd_t            cmd,
	output vca_pkg::vca_stat_t                stat,
	input  wire logic                         out_stall,
	output logic                              out_valid,
	output logic                              accepted,
	output logic [vca_pkg::CHAN_W-1:0]        channel,
	output logic                              key_off,
	output logic                              stolen,
	output logic [vca_pkg::NOTE_W-1:0]        stolen_note,
	output logic [vca_pkg::SEQ_W-1:0]         voice_sequence,
	output logic [vca_pkg::TIME_W-1:0]        voice_on_time,
	output logic [vca_pkg::TIME_W-1:0]        voice_off_time,
	output logic                              last
);

	localparam int N  = vca_pkg::NUM_CHANNELS;
	localparam int CB = vca_pkg::CH_BITS;
	localparam int CW = vca_pkg::COUNT_BITS;
	localparam int TW = vca_pkg::TIME_W;
	localparam int NW = vca_pkg::NOTE_W;

	typedef struct packed {
		logic                             accepted;
		logic [vca_pkg::CHAN_W-1:0]       channel;
		logic                             key_off;
		logic                             stolen;
		logic [NW-1:0]                    stolen_note;
		logic [vca_pkg::SEQ_W-1:0]        seq;
		logic [TW-1:0]                    on_time;
		logic [TW-1:0]                    off_time;
		logic                             last;
	} res_t;

	// event item
	logic [1:0]     act_q;
	logic [NW-1:0]  item_note_q;
	logic           item_steal_q;
	logic [TW-1:0]  item_time_q;

	// channel and voice records
	logic [N-1:0]   held_q;
	logic [NW-1:0]  note_q  [N];
	logic [CW-1:0]  order_q [N];
	logic [CW-1:0]  seq_q   [N];
	logic [TW-1:0]  start_q [N];
	logic [TW-1:0]  end_q   [N];
	logic [CW-1:0]  order_count_q;
	logic [CW-1:0]  voice_count_q;

	// scan results
	logic           match_found_q;
	logic [CB-1:0]  match_idx_q;
	logic [CW-1:0]  match_seq_q;
	logic [TW-1:0]  match_start_q;
	logic [TW-1:0]  match_end_q;
	logic           free_found_q;
	logic [CB-1:0]  free_idx_q;
	logic [CW-1:0]  free_ord_q;
	logic [CB-1:0]  old_idx_q;
	logic [CW-1:0]  old_ord_q;
	logic [NW-1:0]  old_note_q;

	// output register
	logic           out_valid_q;
	res_t           res_q;

	// channel under the walk
	logic           cur_held;
	logic [NW-1:0]  cur_note;
	logic [CW-1:0]  cur_order;
	logic [CW-1:0]  cur_seq;
	logic [TW-1:0]  cur_start;
	logic [TW-1:0]  cur_end;
	logic [TW-1:0]  rel_end;
	logic           higher_held;

	logic [CW-1:0]  new_order;
	logic [CW-1:0]  new_seq;
	logic [CB-1:0]  on_sel;
	logic           on_ok;
	logic           on_stl;
	logic           off_ok;
	logic [TW-1:0]  off_end;
	res_t           res_apply;
	res_t           res_rel;
	res_t           res_empty;

	assign cur_held  = held_q[cmd.idx];
	assign cur_note  = note_q[cmd.idx];
	assign cur_order = order_q[cmd.idx];
	assign cur_seq   = seq_q[cmd.idx];
	assign cur_start = start_q[cmd.idx];
	assign cur_end   = end_q[cmd.idx];
	// a record with sequence zero is no voice and keeps its off time
	assign rel_end   = (cur_seq != '0) ? item_time_q : cur_end;

	always_comb begin
		higher_held = 1'b0;
		for (int k = 0; k < N; k++) begin
			if (CB'(k) > cmd.idx) begin
				higher_held = higher_held | held_q[k];
			end
		end
	end

	assign stat.action    = act_q;
	assign stat.any_held  = |held_q;
	assign stat.idx_held  = cur_held;
	assign stat.last_held = !higher_held;
	assign stat.out_free  = !out_valid_q || !out_stall;

	assign new_order = order_count_q + 1'b1;
	assign new_seq   = voice_count_q + 1'b1;
	assign on_sel    = free_found_q ? free_idx_q : old_idx_q;
	assign on_ok     = !match_found_q && (free_found_q || item_steal_q);
	assign on_stl    = !free_found_q;
	assign off_ok    = match_found_q;
	assign off_end   = (match_seq_q != '0) ? item_time_q : match_end_q;

	always_comb begin
		res_empty      = '0;
		res_empty.last = 1'b1;

		res_apply = res_empty;
		case (vca_pkg::action_t'(act_q))
			vca_pkg::ACT_ON: begin
				if (on_ok) begin
					res_apply.accepted    = 1'b1;
					res_apply.channel     = vca_pkg::CHAN_W'(on_sel);
					res_apply.stolen      = on_stl;
					res_apply.stolen_note = on_stl ? old_note_q : '0;
					res_apply.seq         = vca_pkg::to_seq(new_seq);
					res_apply.on_time     = item_time_q;
					res_apply.off_time    = '0;
				end
			end
			vca_pkg::ACT_OFF: begin
				if (off_ok) begin
					res_apply.accepted = 1'b1;
					res_apply.channel  = vca_pkg::CHAN_W'(match_idx_q);
					res_apply.key_off  = 1'b1;
					res_apply.seq      = vca_pkg::to_seq(match_seq_q);
					res_apply.on_time  = match_start_q;
					res_apply.off_time = off_end;
				end
			end
			default: begin
				res_apply = res_empty;
			end
		endcase

		res_rel          = '0;
		res_rel.accepted = 1'b1;
		res_rel.channel  = vca_pkg::CHAN_W'(cmd.idx);
		res_rel.key_off  = 1'b1;
		res_rel.seq      = vca_pkg::to_seq(cur_seq);
		res_rel.on_time  = cur_start;
		res_rel.off_time = rel_end;
		res_rel.last     = !higher_held;
	end

	// item capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q        <= action;
			item_note_q  <= note;
			item_steal_q <= allow_steal;
			item_time_q  <= sample_time;
		end
	end

	// channel walk: first held match, oldest free, oldest overall
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_found_q <= 1'b0;
			free_found_q  <= 1'b0;
		end else if (cmd.load) begin
			match_found_q <= 1'b0;
			free_found_q  <= 1'b0;
		end else if (cmd.scan) begin
			if (cur_held && (cur_note == item_note_q) && !match_found_q) begin
				match_found_q <= 1'b1;
			end
			if (!cur_held && (!free_found_q || (cur_order < free_ord_q))) begin
				free_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan) begin
			if (cur_held && (cur_note == item_note_q) && !match_found_q) begin
				match_idx_q   <= cmd.idx;
				match_seq_q   <= cur_seq;
				match_start_q <= cur_start;
				match_end_q   <= cur_end;
			end
			if (!cur_held && (!free_found_q || (cur_order < free_ord_q))) begin
				free_idx_q <= cmd.idx;
				free_ord_q <= cur_order;
			end
			if ((cmd.idx == '0) || (cur_order < old_ord_q)) begin
				old_idx_q  <= cmd.idx;
				old_ord_q  <= cur_order;
				old_note_q <= cur_note;
			end
		end
	end

	// record updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q        <= '0;
			order_count_q <= '0;
			voice_count_q <= '0;
			for (int k = 0; k < N; k++) begin
				note_q[k]  <= '0;
				order_q[k] <= '0;
				seq_q[k]   <= '0;
				start_q[k] <= '0;
				end_q[k]   <= '0;
			end
		end else begin
			if (cmd.apply && (vca_pkg::action_t'(act_q) == vca_pkg::ACT_ON) && on_ok) begin
				held_q[on_sel]  <= 1'b1;
				note_q[on_sel]  <= item_note_q;
				order_q[on_sel] <= new_order;
				seq_q[on_sel]   <= new_seq;
				start_q[on_sel] <= item_time_q;
				end_q[on_sel]   <= '0;
				order_count_q   <= new_order;
				voice_count_q   <= new_seq;
			end
			if (cmd.apply && (vca_pkg::action_t'(act_q) == vca_pkg::ACT_OFF) && off_ok) begin
				held_q[match_idx_q] <= 1'b0;
				note_q[match_idx_q] <= '0;
				end_q[match_idx_q]  <= off_end;
			end
			if (cmd.rel_emit) begin
				held_q[cmd.idx]  <= 1'b0;
				note_q[cmd.idx]  <= '0;
				order_q[cmd.idx] <= '0;
				end_q[cmd.idx]   <= rel_end;
				if (!higher_held) begin
					order_count_q <= '0;
				end
			end
			if (cmd.rel_empty) begin
				order_count_q <= '0;
			end
		end
	end

	// output register: load only when empty or draining this cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.apply || cmd.rel_emit || cmd.rel_empty) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.apply) begin
			res_q <= res_apply;
		end else if (cmd.rel_emit) begin
			res_q <= res_rel;
		end else if (cmd.rel_empty) begin
			res_q <= res_empty;
		end
	end

	assign out_valid      = out_valid_q;
	assign accepted       = res_q.accepted;
	assign channel        = res_q.channel;
	assign key_off        = res_q.key_off;
	assign stolen         = res_q.stolen;
	assign stolen_note    = res_q.stolen_note;
	assign voice_sequence = res_q.seq;
	assign voice_on_time  = res_q.on_time;
	assign voice_off_time = res_q.off_time;
	assign last           = res_q.last;

endmodule

`default_nettype wire

// File: rtl/core/voice_channel_allocator_core.sv
// Order: an accepted event is captured, then every channel is walked in turn and the
// decision is loaded into the output register; release all instead walks the channels
// and gives one beat per held channel, skipping free ones, each beat waiting while the
// output is stalled, or a single empty beat when no channel is held.
// Throughput: one event at a time; in_stall holds off the next until its result is issued.
// Reset: all channels free, order and voice counters zero, output empty.
// ----------------------------------------------------------------------------
// voice_channel_allocator_core
// Polyphonic voice allocator with oldest-channel stealing over six channels.
// ----------------------------------------------------------------------------
`default_nettype none

module voice_channel_allocator_core (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [1:0]                  action,
	input  wire logic [vca_pkg::NOTE_W-1:0]  note,
	input  wire logic                        allow_steal,
	input  wire logic [vca_pkg::TIME_W-1:0]  sample_time,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic                             accepted,
	output logic [vca_pkg::CHAN_W-1:0]       channel,
	output logic                             key_off,
	output logic                             stolen,
	output logic [vca_pkg::NOTE_W-1:0]       stolen_note,
	output logic [vca_pkg::SEQ_W-1:0]        voice_sequence,
	output logic [vca_pkg::TIME_W-1:0]       voice_on_time,
	output logic [vca_pkg::TIME_W-1:0]       voice_off_time,
	output logic                             last
);

	vca_pkg::vca_cmd_t  cmd;
	vca_pkg::vca_stat_t stat;

	vca_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	vca_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.action         (action),
		.note           (note),
		.allow_steal    (allow_steal),
		.sample_time    (sample_time),
		.cmd            (cmd),
		.stat           (stat),
		.out_stall      (out_stall),
		.out_valid      (out_valid),
		.accepted       (accepted),
		.channel        (channel),
		.key_off        (key_off),
		.stolen         (stolen),
		.stolen_note    (stolen_note),
		.voice_sequence (voice_sequence),
		.voice_on_time  (voice_on_time),
		.voice_off_time (voice_off_time),
		.last           (last)
	);

endmodule

`default_nettype wire

// File: rtl/core/voice_channel_allocator_core_chk.sv
// ----------------------------------------------------------------------------
// voice_channel_allocator_core_chk
// Port-level checker of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "voice_channel_allocator_core_assert.svh"

module voice_channel_allocator_core_chk (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        out_valid,
	input wire logic                        out_stall,
	input wire logic                        accepted,
	input wire logic [vca_pkg::CHAN_W-1:0]  channel,
	input wire logic                        key_off,
	input wire logic                        stolen,
	input wire logic [vca_pkg::NOTE_W-1:0]  stolen_note,
	input wire logic [vca_pkg::SEQ_W-1:0]   voice_sequence,
	input wire logic [vca_pkg::TIME_W-1:0]  voice_off_time,
	input wire logic                        last
);

	// stalled beat holds
	`VCA_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(channel) && $stable(voice_sequence) && $stable(last),
		"stalled output beat changed")

	// a rejected event is a single empty beat
	`VCA_ASSERT_NOW(a_reject_empty, out_valid && !accepted,
		last && (channel == '0) && !key_off && !stolen && (voice_sequence == '0),
		"rejected beat not empty")

	// a steal is a fresh note on: no key-off, no off time
	`VCA_ASSERT_NOW(a_steal_shape, out_valid && stolen,
		accepted && !key_off && (voice_off_time == '0),
		"steal beat malformed")

	// stolen note only with a steal, channel in range
	`VCA_ASSERT_NOW(a_fields_sane, out_valid,
		(stolen || (stolen_note == '0)) && (int'(channel) < vca_pkg::NUM_CHANNELS),
		"beat fields out of range")

endmodule

bind voice_channel_allocator_core voice_channel_allocator_core_chk u_chk (.*);

`default_nettype wire

// File: dv/tb_voice_channel_allocator_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_voice_channel_allocator_core
// Self-checking bench for the six-channel voice allocator. A short table of
// note events covers the extremes, every action, rejects, stealing and empty
// releases; random note traffic over a small note pool follows in phases of
// sender and receiver idling. Every result beat is checked against a local
// model of the channel and voice state or against a typed beat in the table.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_voice_channel_allocator_core;

	localparam int CLK_PERIOD      = 12;
	localparam int NCH             = vca_pkg::NUM_CHANNELS;
	localparam int NOTE_W          = vca_pkg::NOTE_W;
	localparam int TIME_W          = vca_pkg::TIME_W;
	localparam int CHAN_W          = vca_pkg::CHAN_W;
	localparam int SEQ_W           = vca_pkg::SEQ_W;
	localparam int COUNT_BITS      = vca_pkg::COUNT_BITS;
	localparam int ITEMS_PER_PHASE = 50;
	localparam int POOL_SIZE       = 9;
	localparam int WATCHDOG_LIMIT  = 4000;
	localparam int TAIL_CYCLES     = 4 * (NCH + 2);
	localparam int REPORT_MAX      = 10;
	localparam logic [1:0] ACT_BAD = 2'd3;

	typedef struct packed {
		logic [1:0]        action;
		logic [NOTE_W-1:0] note;
		logic              allow_steal;
		logic [TIME_W-1:0] sample_time;
	} note_event_t;

	typedef struct packed {
		logic              accepted;
		logic [CHAN_W-1:0] channel;
		logic              key_off;
		logic              stolen;
		logic [NOTE_W-1:0] stolen_note;
		logic [SEQ_W-1:0]  voice_sequence;
		logic [TIME_W-1:0] voice_on_time;
		logic [TIME_W-1:0] voice_off_time;
		logic              last;
	} alloc_beat_t;

	typedef struct packed {
		note_event_t ev;
		logic        fixed;
		alloc_beat_t beat;
	} stim_row_t;

	localparam alloc_beat_t REJECT = '{last: 1'b1, default: '0};

	logic              clk         = 1'b0;
	logic              arst_n      = 1'b0;
	logic              in_valid    = 1'b0;
	logic              in_stall;
	logic [1:0]        action      = '0;
	logic [NOTE_W-1:0] note        = '0;
	logic              allow_steal = 1'b0;
	logic [TIME_W-1:0] sample_time = '0;
	logic              out_valid;
	logic              out_stall   = 1'b0;
	logic              accepted;
	logic [CHAN_W-1:0] channel;
	logic              key_off;
	logic              stolen;
	logic [NOTE_W-1:0] stolen_note;
	logic [SEQ_W-1:0]  voice_sequence;
	logic [TIME_W-1:0] voice_on_time;
	logic [TIME_W-1:0] voice_off_time;
	logic              last;

	voice_channel_allocator_core u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.action        (action),
		.note          (note),
		.allow_steal   (allow_steal),
		.sample_time   (sample_time),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.accepted      (accepted),
		.channel       (channel),
		.key_off       (key_off),
		.stolen        (stolen),
		.stolen_note   (stolen_note),
		.voice_sequence(voice_sequence),
		.voice_on_time (voice_on_time),
		.voice_off_time(voice_off_time),
		.last          (last)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Local copy of channel and voice state
	logic                  held      [NCH];
	logic [NOTE_W-1:0]     held_note [NCH];
	logic [COUNT_BITS-1:0] chan_age  [NCH];
	logic [COUNT_BITS-1:0] age_count;
	logic [COUNT_BITS-1:0] voice_count;
	logic [COUNT_BITS-1:0] voice_id  [NCH];
	logic [TIME_W-1:0]     voice_on  [NCH];
	logic [TIME_W-1:0]     voice_off [NCH];

	alloc_beat_t alloc_expect [$];
	alloc_beat_t step_beats [$];
	stim_row_t   dir_rows [$];
	logic [NOTE_W-1:0] note_pool [POOL_SIZE];

	int src_idle_pct  = 0;
	int rcv_stall_pct = 0;
	int fail_count    = 0;

	function automatic void add_step_beat(alloc_beat_t b);
		step_beats = {step_beats, b};
	endfunction

	function automatic alloc_beat_t voice_beat(int ch, logic koff, logic stl,
			logic [NOTE_W-1:0] snote);
		alloc_beat_t b;
		b                = '0;
		b.accepted       = 1'b1;
		b.channel        = ch[CHAN_W-1:0];
		b.key_off        = koff;
		b.stolen         = stl;
		b.stolen_note    = snote;
		b.voice_sequence = voice_id[ch];
		b.voice_on_time  = voice_on[ch];
		b.voice_off_time = voice_off[ch];
		b.last           = 1'b1;
		return b;
	endfunction

	function automatic void release_voice(int ch, logic [TIME_W-1:0] t);
		held[ch]      = 1'b0;
		held_note[ch] = '0;
		// a wrapped sequence of zero is no voice: leave it untouched
		if (voice_id[ch] != '0)
			voice_off[ch] = t;
	endfunction

	function automatic void step_allocator(input note_event_t e);
		int hit, sel, total, n;
		logic stl;
		logic [NOTE_W-1:0] snote;
		alloc_beat_t b;
		step_beats.delete();
		hit   = -1;
		sel   = -1;
		total = 0;
		n     = 0;
		stl   = 1'b0;
		snote = '0;
		for (int i = 0; i < NCH; i++)
			if (hit < 0 && held[i] && held_note[i] == e.note)
				hit = i;
		case (e.action)
			vca_pkg::ACT_ON: begin
				if (hit >= 0) begin
					add_step_beat(REJECT);
				end else begin
					for (int i = 0; i < NCH; i++)
						if (!held[i] && (sel < 0 || chan_age[i] < chan_age[sel]))
							sel = i;
					if (sel < 0 && e.allow_steal) begin
						sel = 0;
						for (int i = 1; i < NCH; i++)
							if (chan_age[i] < chan_age[sel])
								sel = i;
						stl   = 1'b1;
						snote = held_note[sel];
					end
					if (sel < 0) begin
						add_step_beat(REJECT);
					end else begin
						held[sel]      = 1'b1;
						held_note[sel] = e.note;
						age_count      = age_count + 1'b1;
						chan_age[sel]  = age_count;
						voice_count    = voice_count + 1'b1;
						voice_id[sel]  = voice_count;
						voice_on[sel]  = e.sample_time;
						voice_off[sel] = '0;
						add_step_beat(voice_beat(sel, 1'b0, stl, snote));
					end
				end
			end
			vca_pkg::ACT_OFF: begin
				if (hit < 0) begin
					add_step_beat(REJECT);
				end else begin
					release_voice(hit, e.sample_time);
					add_step_beat(voice_beat(hit, 1'b1, 1'b0, '0));
				end
			end
			vca_pkg::ACT_REL: begin
				for (int i = 0; i < NCH; i++)
					if (held[i])
						total++;
				for (int i = 0; i < NCH; i++) begin
					if (held[i]) begin
						release_voice(i, e.sample_time);
						chan_age[i] = '0;
						b           = voice_beat(i, 1'b1, 1'b0, '0);
						b.last      = (n + 1 == total);
						add_step_beat(b);
						n++;
					end
				end
				age_count = '0;
				if (n == 0)
					add_step_beat(REJECT);
			end
			default: add_step_beat(REJECT);
		endcase
	endfunction

	function automatic note_event_t rand_event();
		note_event_t e;
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			e.action = vca_pkg::ACT_ON;
		else if (r < 92)
			e.action = vca_pkg::ACT_OFF;
		else
			e.action = vca_pkg::ACT_REL;
		e.note = note_pool[$urandom_range(0, POOL_SIZE - 1)];
		if ($urandom_range(0, 9) == 0)
			e.note = NOTE_W'($urandom);
		e.allow_steal = ($urandom_range(0, 99) < 70);
		case ($urandom_range(0, 9))
			0:       e.sample_time = '0;
			1:       e.sample_time = '1;
			default: e.sample_time = {$urandom, $urandom};
		endcase
		return e;
	endfunction

	function automatic void add_row(logic [1:0] a, logic [NOTE_W-1:0] n, logic s,
			logic [TIME_W-1:0] t, logic fixed, alloc_beat_t b);
		stim_row_t row;
		row.ev    = '{action: a, note: n, allow_steal: s, sample_time: t};
		row.fixed = fixed;
		row.beat  = b;
		dir_rows  = {dir_rows, row};
	endfunction

	function automatic string beat_text(alloc_beat_t b);
		return $sformatf("acc=%0d ch=%0d koff=%0d stl=%0d snote=%0d seq=%0d on=%h off=%h last=%0d",
			b.accepted, b.channel, b.key_off, b.stolen, b.stolen_note,
			b.voice_sequence, b.voice_on_time, b.voice_off_time, b.last);
	endfunction

	task automatic send_event(input note_event_t ev, input logic fixed,
			input alloc_beat_t typed);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		action      <= ev.action;
		note        <= ev.note;
		allow_steal <= ev.allow_steal;
		sample_time <= ev.sample_time;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		step_allocator(ev);
		if (fixed)
			alloc_expect = {alloc_expect, typed};
		else
			alloc_expect = {alloc_expect, step_beats};
	endtask

	// hold off the sender until every expected beat is out
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (alloc_expect.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin : result_side
		alloc_beat_t got, want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got = '{accepted, channel, key_off, stolen, stolen_note,
					voice_sequence, voice_on_time, voice_off_time, last};
				if (alloc_expect.size() == 0) begin
					if (fail_count < REPORT_MAX)
						$display("unexpected beat: %s", beat_text(got));
					fail_count++;
				end else begin
					want = alloc_expect.pop_front();
					if (got !== want) begin
						if (fail_count < REPORT_MAX) begin
							$display("mismatch expected: %s", beat_text(want));
							$display("mismatch actual:   %s", beat_text(got));
						end
						fail_count++;
					end
				end
			end
			out_stall <= ($urandom_range(0, 99) < rcv_stall_pct);
		end
	end

	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("status: fail");
		$finish;
	end

	initial begin : stimulus
		int ph;
		for (int i = 0; i < NCH; i++) begin
			held[i]      = 1'b0;
			held_note[i] = '0;
			chan_age[i]  = '0;
			voice_id[i]  = '0;
			voice_on[i]  = '0;
			voice_off[i] = '0;
		end
		age_count   = '0;
		voice_count = '0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty release and unmatched note off right after reset
		add_row(vca_pkg::ACT_REL, 7'd0, 1'b0, 64'd0, 1'b1, REJECT);
		add_row(vca_pkg::ACT_OFF, 7'd5, 1'b0, 64'd9, 1'b1, REJECT);
		add_row(vca_pkg::ACT_ON, 7'd0, 1'b0, 64'd0, 1'b1,
			'{accepted: 1'b1, voice_sequence: 32'd1, last: 1'b1, default: '0});
		add_row(vca_pkg::ACT_ON, 7'd0, 1'b1, 64'd5, 1'b1, REJECT);
		add_row(vca_pkg::ACT_ON, 7'd127, 1'b0, '1, 1'b1,
			'{accepted: 1'b1, channel: 3'd1, voice_sequence: 32'd2, voice_on_time: '1,
			last: 1'b1, default: '0});
		add_row(vca_pkg::ACT_ON, 7'd64, 1'b0, 64'd100, 1'b0, '0);
		add_row(vca_pkg::ACT_ON, 7'd1, 1'b0, 64'd200, 1'b0, '0);
		add_row(vca_pkg::ACT_ON, 7'd2, 1'b1, 64'd300, 1'b0, '0);
		add_row(vca_pkg::ACT_ON, 7'd3, 1'b0, 64'h8000_0000_0000_0000, 1'b0, '0);
		// all channels held: reject without steal, then steal the oldest twice
		add_row(vca_pkg::ACT_ON, 7'd9, 1'b0, 64'd400, 1'b1, REJECT);
		add_row(vca_pkg::ACT_ON, 7'd9, 1'b1, 64'd500, 1'b0, '0);
		add_row(vca_pkg::ACT_ON, 7'd10, 1'b1, 64'd600, 1'b0, '0);
		add_row(vca_pkg::ACT_OFF, 7'd64, 1'b0, '1, 1'b0, '0);
		add_row(vca_pkg::ACT_ON, 7'd20, 1'b0, 64'd700, 1'b0, '0);
		add_row(vca_pkg::ACT_OFF, 7'd1, 1'b1, 64'd0, 1'b0, '0);
		add_row(ACT_BAD, 7'd127, 1'b1, '1, 1'b1, REJECT);
		add_row(vca_pkg::ACT_REL, 7'd127, 1'b1, 64'd12345, 1'b0, '0);
		add_row(vca_pkg::ACT_ON, 7'd50, 1'b0, 64'd800, 1'b0, '0);
		add_row(vca_pkg::ACT_OFF, 7'd50, 1'b0, 64'd877, 1'b0, '0);
		add_row(vca_pkg::ACT_REL, 7'd0, 1'b0, 64'd900, 1'b1, REJECT);
		add_row(vca_pkg::ACT_ON, 7'd51, 1'b0, 64'd1000, 1'b0, '0);
		foreach (dir_rows[k])
			send_event(dir_rows[k].ev, dir_rows[k].fixed, dir_rows[k].beat);
		drain_results();

		for (ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin src_idle_pct = 0;  rcv_stall_pct = 0;  end
				1: begin src_idle_pct = 68; rcv_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  rcv_stall_pct = 68; end
				default: begin src_idle_pct = 34; rcv_stall_pct = 34; end
			endcase
			foreach (note_pool[k])
				note_pool[k] = NOTE_W'($urandom);
			repeat (ITEMS_PER_PHASE) begin
				if ($urandom_range(0, 39) == 0)
					drain_results();
				send_event(rand_event(), 1'b0, '0);
			end
			drain_results();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (alloc_expect.size() != 0 && fail_count < REPORT_MAX)
			$display("missing %0d result beats", alloc_expect.size());
		if (fail_count == 0 && alloc_expect.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

`default_nettype wire
